FILE: rtl/efa_pkg.sv
// Shared constants, types and the check table function of the EAPOL frame assembler.
`default_nettype none
package efa_pkg;

   localparam int MIN_FRAME_BYTES = 60;
   localparam int COUNT_WIDTH     = $clog2(MIN_FRAME_BYTES + 1);
   localparam int ADDR_WIDTH      = 48;
   localparam int ADDR_BYTES      = 6;
   localparam int HEADER_BYTES    = 2 * ADDR_BYTES;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEST_ADDRESS   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_ADDRESS = 2'd1;

   localparam logic [ADDR_WIDTH-1:0] DEFAULT_GROUP_ADDR = 48'h0180_C200_0003;
   localparam logic [31:0]           CRC_POLY_REFLECTED = 32'hEDB8_8320;

   // One byte step from the sequencer toward the check unit.
   typedef struct packed {
      logic       step;
      logic       eof;
      logic [7:0] frame_byte;
   } crc_cmd_type;

   // Current configuration as seen by the sequencer.
   typedef struct packed {
      logic [ADDR_WIDTH-1:0] dest_address;
      logic [ADDR_WIDTH-1:0] source_address;
   } cfg_type;

   // Reflected table entry, a pure XOR network over the eight input bits.
   function automatic logic [31:0] crc_table_entry(input logic [7:0] t);
      logic [31:0] v;
      v = {24'd0, t};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY_REFLECTED) : (v >> 1);
      end
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/efa_req_if.sv
// Input channel carrying body bytes and the last flag.
`default_nettype none
interface efa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       last_byte;

   modport source (output valid, output body_byte, output last_byte, input ready);
   modport sink   (input valid, input body_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/efa_rsp_if.sv
// Result channel carrying frame bytes, the end flag and the check value.
`default_nettype none
interface efa_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  frame_byte;
   logic        end_of_frame;
   logic [31:0] check_value;

   modport source (output valid, output frame_byte, output end_of_frame,
                   output check_value, input ready);
   modport sink   (input valid, input frame_byte, input end_of_frame,
                   input check_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/efa_csr_if.sv
// Configuration write channel carrying a register index and write data.
`default_nettype none
interface efa_csr_if
   import efa_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [ADDR_WIDTH-1:0]      wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/efa_csr_regs.sv
// Configuration registers for the destination and source addresses.
`default_nettype none
module efa_csr_regs
   import efa_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   efa_csr_if.sink    csr_ch,
   output cfg_type    cfg
);

   logic [ADDR_WIDTH-1:0] dest_ff, dest_in;
   logic [ADDR_WIDTH-1:0] source_ff, source_in;
   logic                  write;

   assign csr_ch.ready = 1'b1;
   assign write        = csr_ch.valid;

   always_comb begin
      dest_in   = dest_ff;
      source_in = source_ff;
      if (write) begin
         unique case (csr_ch.index)
            CSR_DEST_ADDRESS:   dest_in   = csr_ch.wdata;
            CSR_SOURCE_ADDRESS: source_in = csr_ch.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff   <= '0;
         source_ff <= '0;
      end else begin
         dest_ff   <= dest_in;
         source_ff <= source_in;
      end
   end

   assign cfg.dest_address   = dest_ff;
   assign cfg.source_address = source_ff;

endmodule
`default_nettype wire

FILE: rtl/efa_crc_unit.sv
// Shared check unit: one table step of the 32-bit check register per emitted byte.
`default_nettype none
module efa_crc_unit
   import efa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire crc_cmd_type cmd,
   output logic [31:0]      crc_next
);

   logic [31:0] crc_ff, crc_in;

   assign crc_next = {crc_ff[23:0], cmd.frame_byte} ^ crc_table_entry(crc_ff[31:24]);

   always_comb begin
      crc_in = crc_ff;
      if (cmd.step) begin
         // The register restarts from zero once the frame's last byte is counted.
         crc_in = cmd.eof ? 32'd0 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/efa_sequencer.sv
// Byte sequencer: header, body byte and padding, with the output register.
`default_nettype none
module efa_sequencer
   import efa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   efa_req_if.sink          req_ch,
   efa_rsp_if.source        rsp_ch,
   input  wire cfg_type     cfg,
   output crc_cmd_type      crc_cmd,
   input  wire logic [31:0] crc_next
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_HEADER = 4'b0010,
      S_BODY   = 4'b0100,
      S_PAD    = 4'b1000
   } state_type;

   localparam logic [COUNT_WIDTH-1:0] MIN_COUNT  = COUNT_WIDTH'(MIN_FRAME_BYTES);
   localparam logic [COUNT_WIDTH-1:0] HDR_LAST   = COUNT_WIDTH'(HEADER_BYTES - 1);
   localparam int                     HDR_WIDTH  = 2 * ADDR_WIDTH;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [HDR_WIDTH-1:0]   hdr_ff, hdr_in;
   logic [7:0]             body_ff, body_in;
   logic                   last_ff, last_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_eof_ff, out_eof_in;
   logic [31:0]            out_check_ff, out_check_in;

   logic                   advance;
   logic                   accept;
   logic                   emit;
   logic                   emit_eof;
   logic [7:0]             emit_byte;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic [ADDR_WIDTH-1:0]  dest_sel;

   assign advance   = !out_valid_ff || rsp_ch.ready;
   assign accept    = req_ch.valid && req_ch.ready;
   assign count_inc = (count_ff < MIN_COUNT) ? count_ff + 1'b1 : count_ff;
   assign dest_sel  = (cfg.dest_address == '0) ? DEFAULT_GROUP_ADDR : cfg.dest_address;

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      hdr_in    = hdr_ff;
      body_in   = body_ff;
      last_in   = last_ff;
      emit      = 1'b0;
      emit_eof  = 1'b0;
      emit_byte = 8'd0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               body_in = req_ch.body_byte;
               last_in = req_ch.last_byte;
               // The addresses are sampled only when a new frame starts.
               if (count_ff == '0) begin
                  hdr_in   = {dest_sel, cfg.source_address};
                  state_in = S_HEADER;
               end else begin
                  state_in = S_BODY;
               end
            end
         end
         S_HEADER: begin
            if (advance) begin
               emit      = 1'b1;
               emit_byte = hdr_ff[HDR_WIDTH-1 -: 8];
               hdr_in    = {hdr_ff[HDR_WIDTH-9:0], 8'd0};
               count_in  = count_inc;
               if (count_ff == HDR_LAST) begin
                  state_in = S_BODY;
               end
            end
         end
         S_BODY: begin
            if (advance) begin
               emit      = 1'b1;
               emit_byte = body_ff;
               count_in  = count_inc;
               if (last_ff) begin
                  if (count_inc >= MIN_COUNT) begin
                     emit_eof = 1'b1;
                     count_in = '0;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_PAD;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PAD: begin
            if (advance) begin
               emit      = 1'b1;
               emit_byte = 8'd0;
               count_in  = count_inc;
               if (count_inc >= MIN_COUNT) begin
                  emit_eof = 1'b1;
                  count_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_byte_in  = out_byte_ff;
      out_eof_in   = out_eof_ff;
      out_check_in = out_check_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_eof_in   = emit_eof;
         out_check_in = emit_eof ? crc_next : 32'd0;
      end
   end

   assign crc_cmd.step       = emit;
   assign crc_cmd.eof        = emit_eof;
   assign crc_cmd.frame_byte = emit_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      body_ff      <= body_in;
      last_ff      <= last_in;
      out_byte_ff  <= out_byte_in;
      out_eof_ff   <= out_eof_in;
      out_check_ff <= out_check_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.frame_byte   = out_byte_ff;
   assign rsp_ch.end_of_frame = out_eof_ff;
   assign rsp_ch.check_value  = out_check_ff;

   // A frame end always leaves the byte count cleared for the next header.
   a_eof_clears_count: assert property (@(posedge clock) disable iff (reset)
      emit_eof |=> count_ff == '0)
      else $error("byte count not cleared after frame end");

   // Padding is only entered for a frame whose last body byte has been taken.
   a_pad_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PAD |-> last_ff)
      else $error("padding without a last body byte");

   // The header never runs past its twelve address bytes.
   a_header_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HEADER |-> count_ff <= HDR_LAST)
      else $error("header byte index out of range");

   // Only the frame's final byte carries a check value.
   a_check_only_at_eof: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_eof_ff |-> out_check_ff == 32'd0)
      else $error("check value on a byte that does not end the frame");

endmodule
`default_nettype wire

FILE: rtl/eapol_frame_assembler_with_crc.sv
// Top level of the EAPOL frame assembler with padding and a 32-bit check value.
// After acceptance the sequencer moves to the header state (or body state mid-frame), which
// emits the first result byte into the output register. A body byte is taken only while idle,
// so no new byte is accepted until the previous one has been emitted (for a frame's first byte,
// after its 12 header bytes); padding needs no input; a stalled output holds the sequencer.
// Reset: synchronous; clears addresses, the check register, the byte count and the output.
`default_nettype none
module eapol_frame_assembler_with_crc
   import efa_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   efa_req_if.sink   req_ch,
   efa_rsp_if.source rsp_ch,
   efa_csr_if.sink   csr_ch
);

   cfg_type     cfg;
   crc_cmd_type crc_cmd;
   logic [31:0] crc_next;

   efa_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   efa_crc_unit u_crc_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (crc_cmd),
      .crc_next (crc_next)
   );

   efa_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .cfg      (cfg),
      .crc_cmd  (crc_cmd),
      .crc_next (crc_next)
   );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the frame assembler: header, body, padding and check value.
module testbench
   import efa_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 10;
   localparam int RANDOM_ITEMS  = 400;
   localparam int PAUSE_AT_ITEM = 200;
   localparam int LONG_HOLD_AT  = 700;
   localparam int LONG_HOLD_LEN = 300;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic        end_of_frame;
      logic [31:0] check_value;
   } frame_beat_type;

   // One row of the directed plan: either a register write or a body byte.
   typedef struct packed {
      logic                       is_csr;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [ADDR_WIDTH-1:0]      wdata;
      logic [7:0]                 body;
      logic                       last;
      logic                       first_known;
      logic [7:0]                 first_byte;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   efa_req_if req_ch();
   efa_rsp_if rsp_ch();
   efa_csr_if csr_ch();

   eapol_frame_assembler_with_crc u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predictor state.
   logic [ADDR_WIDTH-1:0] dest_addr_m;
   logic [ADDR_WIDTH-1:0] src_addr_m;
   logic [31:0]           check_acc;
   int                    frame_len;
   logic [31:0]           crc_lut [256];

   frame_beat_type pending_frame_bytes[$];
   plan_row_type   directed_plan[$];

   int  mismatch_count = 0;
   int  results_seen   = 0;
   int  cycle_count    = 0;
   bit  sender_no_gaps = 1'b0;
   bit  hold_done      = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_WIDTH-1:0] index,
                                            input logic [ADDR_WIDTH-1:0] wdata);
      plan_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.index  = index;
      row.wdata  = wdata;
      return row;
   endfunction

   function automatic plan_row_type item_row(input logic [7:0] body, input logic last,
                                             input logic first_known,
                                             input logic [7:0] first_byte);
      plan_row_type row;
      row = '0;
      row.body        = body;
      row.last        = last;
      row.first_known = first_known;
      row.first_byte  = first_byte;
      return row;
   endfunction

   // Works out every frame byte that one body byte causes and queues them.
   // With force_first set, the first queued byte is the one typed into the plan.
   task automatic assemble_frame_bytes(input logic [7:0] body, input logic last,
                                       input logic force_first, input logic [7:0] first_byte);
      logic [7:0]            seq[$];
      logic [ADDR_WIDTH-1:0] dst;
      frame_beat_type        beat;
      if (frame_len == 0) begin
         check_acc = '0;
         dst = (dest_addr_m == '0) ? DEFAULT_GROUP_ADDR : dest_addr_m;
         for (int k = ADDR_BYTES - 1; k >= 0; k--) seq.push_back(dst[8*k +: 8]);
         for (int k = ADDR_BYTES - 1; k >= 0; k--) seq.push_back(src_addr_m[8*k +: 8]);
      end
      seq.push_back(body);
      if (last) begin
         while (frame_len + seq.size() < MIN_FRAME_BYTES) seq.push_back(8'h00);
      end
      for (int i = 0; i < seq.size(); i++) begin
         check_acc = ((check_acc << 8) | {24'h0, seq[i]}) ^ crc_lut[check_acc[31:24]];
         beat.frame_byte   = (i == 0 && force_first) ? first_byte : seq[i];
         beat.end_of_frame = last && (i == seq.size() - 1);
         beat.check_value  = beat.end_of_frame ? check_acc : 32'h0;
         pending_frame_bytes.push_back(beat);
      end
      frame_len = frame_len + seq.size();
      if (frame_len > MIN_FRAME_BYTES) frame_len = MIN_FRAME_BYTES;
      if (last) begin
         check_acc = '0;
         frame_len = 0;
      end
   endtask

   task automatic send_item(input logic [7:0] body, input logic last,
                            input logic force_first, input logic [7:0] first_byte);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.body_byte <= body;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      assemble_frame_bytes(body, last, force_first, first_byte);
   endtask

   // Drops the request and waits until every queued frame byte has come out.
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [ADDR_WIDTH-1:0] wdata);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.wdata <= wdata;
      do @(posedge clock); while (!csr_ch.ready);
      if (index == CSR_DEST_ADDRESS) dest_addr_m = wdata;
      else if (index == CSR_SOURCE_ADDRESS) src_addr_m = wdata;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [ADDR_WIDTH-1:0] pick_address();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return 48'h0000_0000_0001;
         default: return wide[ADDR_WIDTH-1:0];
      endcase
   endfunction

   function automatic int pick_body_length(input int frame_no);
      int r;
      case (frame_no)
         0: return 47;
         1: return 48;
         2: return 49;
         3: return 75;
         default: ;
      endcase
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(1, 8);
      if (r < 8) return $urandom_range(9, 47);
      if (r < 9) return $urandom_range(44, 52);
      return $urandom_range(53, 90);
   endfunction

   // Result checker: every accepted transaction is matched against the oldest expectation.
   always @(posedge clock) begin
      frame_beat_type exp_beat;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_frame_bytes.size() == 0) begin
            $error("unexpected transaction: frame_byte %02h end_of_frame %0d check_value %08h",
                   rsp_ch.frame_byte, rsp_ch.end_of_frame, rsp_ch.check_value);
            mismatch_count++;
         end else begin
            exp_beat = pending_frame_bytes.pop_front();
            if (rsp_ch.frame_byte !== exp_beat.frame_byte) begin
               $error("frame_byte: expected %02h, got %02h",
                      exp_beat.frame_byte, rsp_ch.frame_byte);
               mismatch_count++;
            end
            if (rsp_ch.end_of_frame !== exp_beat.end_of_frame) begin
               $error("end_of_frame: expected %0d, got %0d",
                      exp_beat.end_of_frame, rsp_ch.end_of_frame);
               mismatch_count++;
            end
            if (rsp_ch.check_value !== exp_beat.check_value) begin
               $error("check_value: expected %08h, got %08h",
                      exp_beat.check_value, rsp_ch.check_value);
               mismatch_count++;
            end
         end
      end
   end

   // Receiver: random stalls per transaction, stall-free stretches, and one long hold-off.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         gap = (((results_seen / 150) % 4) == 2) ? 0 : $urandom_range(0, 6);
         if (!hold_done && results_seen >= LONG_HOLD_AT) begin
            gap       = LONG_HOLD_LEN;
            hold_done = 1'b1;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [31:0]  prev;
      plan_row_type row;
      int           items_sent;
      int           frame_no;
      int           body_len;

      req_ch.valid     = 1'b0;
      req_ch.body_byte = '0;
      req_ch.last_byte = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.wdata     = '0;

      // Reflected table: single-bit entries by stepping down from the top bit,
      // the rest by linearity.
      crc_lut[0]     = '0;
      crc_lut[8'h80] = CRC_POLY_REFLECTED;
      for (int k = 6; k >= 0; k--) begin
         prev = crc_lut[1 << (k + 1)];
         crc_lut[1 << k] = prev[0] ? ((prev >> 1) ^ CRC_POLY_REFLECTED) : (prev >> 1);
      end
      for (int i = 1; i < 256; i++) crc_lut[i] = crc_lut[i & (i - 1)] ^ crc_lut[i & -i];

      dest_addr_m = '0;
      src_addr_m  = '0;
      check_acc   = '0;
      frame_len   = 0;

      directed_plan.push_back(item_row(8'h00, 1'b1, 1'b1, 8'h01));
      directed_plan.push_back(csr_row(CSR_DEST_ADDRESS, 48'hFFFF_FFFF_FFFF));
      directed_plan.push_back(csr_row(CSR_SOURCE_ADDRESS, 48'hFFFF_FFFF_FFFF));
      directed_plan.push_back(item_row(8'hFF, 1'b0, 1'b1, 8'hFF));
      directed_plan.push_back(item_row(8'hA5, 1'b0, 1'b0, 8'h00));
      directed_plan.push_back(item_row(8'h5A, 1'b1, 1'b0, 8'h00));
      directed_plan.push_back(csr_row(CSR_DEST_ADDRESS, 48'h0000_0000_0001));
      directed_plan.push_back(csr_row(CSR_SOURCE_ADDRESS, 48'h0000_0000_0000));
      directed_plan.push_back(item_row(8'h80, 1'b1, 1'b1, 8'h00));
      // The address changes in the middle of a frame; only the next header sees it.
      directed_plan.push_back(item_row(8'h01, 1'b0, 1'b1, 8'h00));
      directed_plan.push_back(csr_row(CSR_DEST_ADDRESS, 48'h1234_5678_9ABC));
      directed_plan.push_back(item_row(8'h02, 1'b0, 1'b0, 8'h00));
      directed_plan.push_back(item_row(8'h7F, 1'b1, 1'b0, 8'h00));
      directed_plan.push_back(item_row(8'h03, 1'b1, 1'b1, 8'h12));
      directed_plan.push_back(csr_row(CSR_DEST_ADDRESS, 48'h0000_0000_0000));
      directed_plan.push_back(csr_row(CSR_SOURCE_ADDRESS, 48'h0211_2233_4455));
      directed_plan.push_back(item_row(8'h55, 1'b0, 1'b1, 8'h01));
      directed_plan.push_back(item_row(8'hAA, 1'b0, 1'b0, 8'h00));
      directed_plan.push_back(item_row(8'h0F, 1'b0, 1'b0, 8'h00));
      directed_plan.push_back(item_row(8'hF0, 1'b1, 1'b0, 8'h00));
      directed_plan.push_back(item_row(8'hFF, 1'b1, 1'b1, 8'h01));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         row = directed_plan[i];
         if (row.is_csr) begin
            wait_for_drain();
            write_csr(row.index, row.wdata);
         end else begin
            send_item(row.body, row.last, row.first_known, row.first_byte);
         end
      end

      // Random frames, with a new address pair every few frames.
      items_sent = 0;
      frame_no   = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (frame_no % 6 == 5) begin
            wait_for_drain();
            write_csr(CSR_DEST_ADDRESS, pick_address());
            write_csr(CSR_SOURCE_ADDRESS, pick_address());
         end
         body_len = pick_body_length(frame_no);
         for (int b = 0; b < body_len; b++) begin
            sender_no_gaps = ((items_sent / 40) % 4) == 1;
            send_item(8'($urandom_range(0, 255)), b == body_len - 1, 1'b0, 8'h00);
            items_sent++;
            if (items_sent == PAUSE_AT_ITEM) wait_for_drain();
         end
         frame_no++;
      end

      wait_for_drain();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
